### rtl/gdr_pkg.sv
`timescale 1ns / 1ps

package gdr_pkg;

  // default sizes
  localparam int MAP_SIZE_DEF  = 32;
  localparam int TEX_WIDTH_DEF = 124;
  localparam int QUEUE_DEPTH   = 4;

  // config port
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  // datapath widths
  localparam int DIV_W = 32;
  localparam int RAY_W = 30;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y,
    REG_SCREEN_W,
    REG_SCREEN_H
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE,
    OP_CAST
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
    logic [9:0] column;
  } item_t;

  typedef struct packed {
    logic        [15:0] pos_x;
    logic        [15:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic        [10:0] screen_width;
    logic        [10:0] screen_height;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CAM_WAIT,
    ST_RAY_X,
    ST_RAY_Y,
    ST_DX_DIV,
    ST_DX_WAIT,
    ST_SX_MUL,
    ST_DY_DIV,
    ST_DY_WAIT,
    ST_SY_MUL,
    ST_START,
    ST_WALK,
    ST_CHK,
    ST_PERP,
    ST_LINE_DIV,
    ST_LINE_WAIT,
    ST_DRAW,
    ST_FIN
  } back_state_t;

endpackage

### rtl/gdr_ram.sv
`timescale 1ns / 1ps

module gdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gdr_div.sv
`timescale 1ns / 1ps

module gdr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [gdr_pkg::DIV_W-1:0] dividend,
  input  logic [gdr_pkg::DIV_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [gdr_pkg::DIV_W-1:0] quo,
  output logic [gdr_pkg::DIV_W-1:0] rem
);

  localparam int W  = gdr_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

endmodule

### rtl/gdr_fifo.sv
`timescale 1ns / 1ps

module gdr_fifo #(
  parameter int DEPTH = gdr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gdr_pkg::item_t item_in,
  input  logic           pop,
  output gdr_pkg::item_t item_out,
  output logic           full,
  output logic           empty
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  gdr_pkg::item_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full     = count == (PW + 1)'(DEPTH);
  assign empty    = count == '0;
  assign item_out = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

### rtl/gdr_front.sv
`timescale 1ns / 1ps

module gdr_front #(
  parameter int MAP_SIZE = gdr_pkg::MAP_SIZE_DEF
) (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           req_type,
  input  logic [4:0]     cell_x,
  input  logic [4:0]     cell_y,
  input  logic [7:0]     cell_value,
  input  logic [9:0]     column,
  input  logic           clearing,
  input  logic           fifo_full,
  output logic           push,
  output gdr_pkg::item_t push_item
);

  logic accept;
  logic in_map;
  logic is_cast;

  // hold off while the map is being cleared or the queue is full
  assign in_stall = fifo_full | clearing;
  assign accept   = in_valid & ~in_stall;

  // classify: casts always go on, writes only inside the map
  assign is_cast = req_type;
  assign in_map  = (7'(cell_x) < 7'(MAP_SIZE)) && (7'(cell_y) < 7'(MAP_SIZE));
  assign push    = accept & (is_cast | in_map);

  always_comb begin
    push_item.op         = is_cast ? gdr_pkg::OP_CAST : gdr_pkg::OP_WRITE;
    push_item.cell_x     = cell_x;
    push_item.cell_y     = cell_y;
    push_item.cell_value = cell_value;
    push_item.column     = column;
  end

endmodule

### rtl/gdr_back.sv
`timescale 1ns / 1ps

module gdr_back #(
  parameter int MAP_SIZE  = gdr_pkg::MAP_SIZE_DEF,
  parameter int TEX_WIDTH = gdr_pkg::TEX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  gdr_pkg::cfg_t  cfg,
  input  logic           fifo_empty,
  input  gdr_pkg::item_t fifo_item,
  output logic           fifo_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [9:0]     column_out,
  output logic [9:0]     draw_start,
  output logic [9:0]     draw_end,
  output logic [6:0]     tex_column,
  output logic           hit_side,
  output logic           escaped
);

  localparam int IW       = $clog2(MAP_SIZE);
  localparam int MW       = IW + 2;
  localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
  localparam int AW       = $clog2(DEPTH);
  localparam int STEP_MAX = 4 * MAP_SIZE + 4;
  localparam int SCW      = $clog2(STEP_MAX + 1);
  localparam int TW       = $clog2(TEX_WIDTH + 1);
  localparam int RW       = gdr_pkg::RAY_W;
  localparam int DW       = gdr_pkg::DIV_W;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [MW-1:0] MAP_LIM   = MW'(MAP_SIZE);
  localparam logic [SCW-1:0]       STEP_LIM  = SCW'(STEP_MAX);
  localparam logic [TW-1:0]        TEX_LAST  = TW'(TEX_WIDTH - 1);

  gdr_pkg::back_state_t state, state_next;
  gdr_pkg::item_t       cur;

  // work registers
  logic [AW-1:0]        clr_addr;
  logic signed [28:0]   cam;
  logic signed [RW-1:0] rx, ry;
  logic [31:0]          dx, dy, sx, sy, perp;
  logic signed [MW-1:0] mx, my;
  logic [SCW-1:0]       steps;
  logic                 side, esc;
  logic [26:0]          line;
  logic [29:0]          wall_frac;
  logic [TW-1:0]        tex;
  logic [9:0]           start_row, end_row;

  // control outputs
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;

  // datapath
  logic [10:0]          w_eff, h_eff, two_c, cam_mag;
  logic                 cam_neg;
  logic signed [28:0]   cam_q;
  logic signed [15:0]   mul_a, dir_sel;
  logic signed [44:0]   ray_prod;
  logic signed [RW-1:0] ray_new;
  logic [RW-1:0]        rx_mag, ry_mag;
  logic [10:0]          f_sel;
  logic [31:0]          d_sel;
  logic [42:0]          side_prod;
  logic [31:0]          side_val;
  logic                 step_x, off_map, out_free, mirror;
  logic signed [MW-1:0] dmx, dmy, nmx, nmy;
  logic [32:0]          sx_add, sy_add;
  logic [AW-1:0]        wr_cell;
  logic [31:0]          perp_val;
  logic [RW-1:0]        ray_w;
  logic [15:0]          pos_w;
  logic [29:0]          wall_mul;
  logic [9:0]           half_h;
  logic [25:0]          half_l;
  logic [26:0]          end_sum;
  logic [40:0]          tex_prod;
  logic [TW-1:0]        tex_m;

  gdr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // screen size with zero values fixed up and the height capped at 1024
  assign w_eff = (cfg.screen_width == '0) ? 11'd1 : cfg.screen_width;
  assign h_eff = (cfg.screen_height == '0) ? 11'd1 :
                 (cfg.screen_height > 11'd1024) ? 11'd1024 : cfg.screen_height;

  // camera coordinate numerator sign and magnitude
  assign two_c   = {cur.column, 1'b0};
  assign cam_neg = two_c < w_eff;
  assign cam_mag = cam_neg ? (w_eff - two_c) : (two_c - w_eff);
  assign cam_q   = {1'b0, div_quo[27:0]};

  // ray = dir + floor(plane * cam / 2^16)
  assign mul_a    = (state == gdr_pkg::ST_RAY_X) ? cfg.plane_x : cfg.plane_y;
  assign dir_sel  = (state == gdr_pkg::ST_RAY_X) ? cfg.dir_x : cfg.dir_y;
  assign ray_prod = mul_a * cam;
  assign ray_new  = RW'(ray_prod >>> 16) + RW'(dir_sel);
  assign rx_mag   = rx[RW-1] ? RW'(-rx) : RW'(rx);
  assign ry_mag   = ry[RW-1] ? RW'(-ry) : RW'(ry);

  // initial side distance from the cell fraction
  always_comb begin
    if (state == gdr_pkg::ST_SX_MUL) begin
      f_sel = rx[RW-1] ? {1'b0, cfg.pos_x[9:0]} : (11'd1024 - {1'b0, cfg.pos_x[9:0]});
      d_sel = dx;
    end else begin
      f_sel = ry[RW-1] ? {1'b0, cfg.pos_y[9:0]} : (11'd1024 - {1'b0, cfg.pos_y[9:0]});
      d_sel = dy;
    end
  end
  assign side_prod = 43'(f_sel) * 43'(d_sel);
  assign side_val  = side_prod[42] ? gdr_pkg::SAT32 : side_prod[41:10];

  // one dda step
  assign step_x  = sx < sy;
  assign dmx     = rx[RW-1] ? '1 : MW'(1);
  assign dmy     = ry[RW-1] ? '1 : MW'(1);
  assign nmx     = step_x ? (mx + dmx) : mx;
  assign nmy     = step_x ? my : (my + dmy);
  assign off_map = (nmx < 0) || (nmy < 0) || (nmx >= MAP_LIM) || (nmy >= MAP_LIM);
  assign sx_add  = {1'b0, sx} + {1'b0, dx};
  assign sy_add  = {1'b0, sy} + {1'b0, dy};

  assign wr_cell = AW'(cur.cell_x) * AW'(MAP_SIZE) + AW'(cur.cell_y);

  // perpendicular distance and hit point fraction
  always_comb begin
    if (side) begin
      perp_val = (sy >= dy) ? (sy - dy) : '0;
    end else begin
      perp_val = (sx >= dx) ? (sx - dx) : '0;
    end
  end
  assign ray_w    = side ? $unsigned(rx) : $unsigned(ry);
  assign pos_w    = side ? cfg.pos_x : cfg.pos_y;
  assign wall_mul = perp[29:0] * ray_w;

  // wall strip rows
  assign half_h  = h_eff[10:1];
  assign half_l  = line[26:1];
  assign end_sum = 27'(half_h) + 27'(half_l);
  assign tex_prod = 41'(wall_frac) * 41'(TEX_WIDTH);

  assign mirror = (!side && !rx[RW-1] && (rx != '0)) || (side && ry[RW-1]);
  assign tex_m  = mirror ? (TEX_LAST - tex) : tex;

  assign out_free = !out_valid || !out_stall;
  assign clearing = state == gdr_pkg::ST_CLEAR;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gdr_pkg::ST_CLEAR:     if (clr_addr == LAST_ADDR) state_next = gdr_pkg::ST_IDLE;
      gdr_pkg::ST_IDLE:      if (!fifo_empty) state_next = gdr_pkg::ST_EXEC;
      gdr_pkg::ST_EXEC: begin
        state_next = (cur.op == gdr_pkg::OP_CAST) ? gdr_pkg::ST_CAM_WAIT : gdr_pkg::ST_IDLE;
      end
      gdr_pkg::ST_CAM_WAIT:  if (div_done) state_next = gdr_pkg::ST_RAY_X;
      gdr_pkg::ST_RAY_X:     state_next = gdr_pkg::ST_RAY_Y;
      gdr_pkg::ST_RAY_Y:     state_next = gdr_pkg::ST_DX_DIV;
      gdr_pkg::ST_DX_DIV: begin
        state_next = (rx == '0) ? gdr_pkg::ST_DY_DIV : gdr_pkg::ST_DX_WAIT;
      end
      gdr_pkg::ST_DX_WAIT:   if (div_done) state_next = gdr_pkg::ST_SX_MUL;
      gdr_pkg::ST_SX_MUL:    state_next = gdr_pkg::ST_DY_DIV;
      gdr_pkg::ST_DY_DIV: begin
        state_next = (ry == '0) ? gdr_pkg::ST_START : gdr_pkg::ST_DY_WAIT;
      end
      gdr_pkg::ST_DY_WAIT:   if (div_done) state_next = gdr_pkg::ST_SY_MUL;
      gdr_pkg::ST_SY_MUL:    state_next = gdr_pkg::ST_START;
      gdr_pkg::ST_START: begin
        if ((7'(cfg.pos_x[15:10]) >= 7'(MAP_SIZE)) || (7'(cfg.pos_y[15:10]) >= 7'(MAP_SIZE))) begin
          state_next = gdr_pkg::ST_FIN;
        end else begin
          state_next = gdr_pkg::ST_WALK;
        end
      end
      gdr_pkg::ST_WALK: begin
        state_next = (steps == STEP_LIM || off_map) ? gdr_pkg::ST_FIN : gdr_pkg::ST_CHK;
      end
      gdr_pkg::ST_CHK: begin
        state_next = (ram_rdata != '0) ? gdr_pkg::ST_PERP : gdr_pkg::ST_WALK;
      end
      gdr_pkg::ST_PERP:      state_next = gdr_pkg::ST_LINE_DIV;
      gdr_pkg::ST_LINE_DIV:  state_next = gdr_pkg::ST_LINE_WAIT;
      gdr_pkg::ST_LINE_WAIT: if (div_done) state_next = gdr_pkg::ST_DRAW;
      gdr_pkg::ST_DRAW:      state_next = gdr_pkg::ST_FIN;
      gdr_pkg::ST_FIN:       if (out_free) state_next = gdr_pkg::ST_IDLE;
      default:               state_next = gdr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = clr_addr;
    ram_wdata    = '0;
    ram_raddr    = AW'(nmx[IW-1:0]) * AW'(MAP_SIZE) + AW'(nmy[IW-1:0]);
    fifo_pop     = 1'b0;
    div_start    = 1'b0;
    div_dividend = {5'b0, cam_mag, 16'b0};
    div_divisor  = {21'b0, w_eff};
    case (state)
      gdr_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      gdr_pkg::ST_IDLE: begin
        fifo_pop = !fifo_empty;
      end
      gdr_pkg::ST_EXEC: begin
        ram_we    = cur.op == gdr_pkg::OP_WRITE;
        ram_waddr = wr_cell;
        ram_wdata = cur.cell_value;
        div_start = cur.op == gdr_pkg::OP_CAST;
      end
      gdr_pkg::ST_DX_DIV: begin
        div_start    = rx != '0;
        div_dividend = 32'h4000_0000;
        div_divisor  = {2'b0, rx_mag};
      end
      gdr_pkg::ST_DY_DIV: begin
        div_start    = ry != '0;
        div_dividend = 32'h4000_0000;
        div_divisor  = {2'b0, ry_mag};
      end
      gdr_pkg::ST_LINE_DIV: begin
        div_start    = 1'b1;
        div_dividend = {5'b0, h_eff, 16'b0};
        div_divisor  = (perp == '0) ? 32'd1 : perp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == gdr_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // cast datapath registers
  always_ff @(posedge clk) begin
    case (state)
      gdr_pkg::ST_IDLE: begin
        cur <= fifo_item;
      end
      gdr_pkg::ST_EXEC: begin
        esc <= 1'b0;
      end
      gdr_pkg::ST_CAM_WAIT: begin
        if (div_done) begin
          if (cam_neg) begin
            cam <= (div_rem != '0) ? -(cam_q + 29'sd1) : -cam_q;
          end else begin
            cam <= cam_q;
          end
        end
      end
      gdr_pkg::ST_RAY_X: rx <= ray_new;
      gdr_pkg::ST_RAY_Y: ry <= ray_new;
      gdr_pkg::ST_DX_DIV: begin
        if (rx == '0) begin
          dx <= gdr_pkg::SAT32;
          sx <= gdr_pkg::SAT32;
        end
      end
      gdr_pkg::ST_DX_WAIT: if (div_done) dx <= div_quo;
      gdr_pkg::ST_SX_MUL:  sx <= side_val;
      gdr_pkg::ST_DY_DIV: begin
        if (ry == '0) begin
          dy <= gdr_pkg::SAT32;
          sy <= gdr_pkg::SAT32;
        end
      end
      gdr_pkg::ST_DY_WAIT: if (div_done) dy <= div_quo;
      gdr_pkg::ST_SY_MUL:  sy <= side_val;
      gdr_pkg::ST_START: begin
        mx    <= $signed(MW'(cfg.pos_x[15:10]));
        my    <= $signed(MW'(cfg.pos_y[15:10]));
        steps <= '0;
        side  <= 1'b0;
        esc   <= (7'(cfg.pos_x[15:10]) >= 7'(MAP_SIZE)) ||
                 (7'(cfg.pos_y[15:10]) >= 7'(MAP_SIZE));
      end
      gdr_pkg::ST_WALK: begin
        if (steps == STEP_LIM || off_map) begin
          esc <= 1'b1;
        end else begin
          steps <= steps + 1'b1;
          mx    <= nmx;
          my    <= nmy;
          side  <= !step_x;
          if (step_x) begin
            sx <= sx_add[32] ? gdr_pkg::SAT32 : sx_add[31:0];
          end else begin
            sy <= sy_add[32] ? gdr_pkg::SAT32 : sy_add[31:0];
          end
        end
      end
      gdr_pkg::ST_PERP: perp <= perp_val;
      gdr_pkg::ST_LINE_DIV: begin
        wall_frac <= {pos_w[9:0], 20'b0} + wall_mul;
      end
      gdr_pkg::ST_LINE_WAIT: if (div_done) line <= div_quo[26:0];
      gdr_pkg::ST_DRAW: begin
        start_row <= (26'(half_h) < half_l) ? '0 : (half_h - half_l[9:0]);
        end_row   <= (end_sum >= 27'(h_eff)) ? 10'(h_eff - 11'd1) : end_sum[9:0];
        tex       <= TW'(tex_prod[40:30]);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == gdr_pkg::ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gdr_pkg::ST_FIN && out_free) begin
      column_out <= cur.column;
      escaped    <= esc;
      draw_start <= esc ? '0 : start_row;
      draw_end   <= esc ? '0 : end_row;
      tex_column <= esc ? '0 : 7'(tex_m);
      hit_side   <= esc ? 1'b0 : side;
    end
  end

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == gdr_pkg::ST_CLEAR || state == gdr_pkg::ST_EXEC))
    else $error("map written outside clear or cell write");
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_chk_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == gdr_pkg::ST_CHK) |-> ($past(state) == gdr_pkg::ST_WALK))
    else $error("map check without a step");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> (state == gdr_pkg::ST_IDLE))
    else $error("queue popped while engine busy");

endmodule

### rtl/grid_dda_column_raycaster_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_stall    req_type, cell_x, cell_y, cell_value, column
// out       out        out_valid / out_stall  column_out, draw_start, draw_end, tex_column,
//                                             hit_side, escaped
//
// a cell write passes through the engine's idle and exec states; a cast takes up to
// 4*MAP_SIZE+4 dda steps and up to four runs of the shared divider; an axis with a
// zero ray skips its run, and an escaped ray skips the height division
// reset starts a clear sweep of all MAP_SIZE*MAP_SIZE map cells, with in_stall high
// a 4-entry queue sits between intake and engine, so intake runs while a cast is busy
// in_stall rises when the queue is full; out_stall holds the result register and the engine

module grid_dda_column_raycaster_unit #(
  parameter int MAP_SIZE  = gdr_pkg::MAP_SIZE_DEF,
  parameter int TEX_WIDTH = gdr_pkg::TEX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [gdr_pkg::IDX_W-1:0] cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [4:0]                cell_x,
  input  logic [4:0]                cell_y,
  input  logic [7:0]                cell_value,
  input  logic [9:0]                column,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [9:0]                column_out,
  output logic [9:0]                draw_start,
  output logic [9:0]                draw_end,
  output logic [6:0]                tex_column,
  output logic                      hit_side,
  output logic                      escaped
);

  gdr_pkg::cfg_t  cfg;
  gdr_pkg::item_t push_item, head_item;
  logic           push, pop, fifo_full, fifo_empty, clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x         <= 16'd2048;
      cfg.pos_y         <= 16'd2048;
      cfg.dir_x         <= -16'sd16384;
      cfg.dir_y         <= '0;
      cfg.plane_x       <= '0;
      cfg.plane_y       <= 16'sd10813;
      cfg.screen_width  <= 11'd640;
      cfg.screen_height <= 11'd480;
    end else if (cfg_we) begin
      case (gdr_pkg::reg_idx_t'(cfg_index))
        gdr_pkg::REG_POS_X:    cfg.pos_x         <= cfg_data;
        gdr_pkg::REG_POS_Y:    cfg.pos_y         <= cfg_data;
        gdr_pkg::REG_DIR_X:    cfg.dir_x         <= $signed(cfg_data);
        gdr_pkg::REG_DIR_Y:    cfg.dir_y         <= $signed(cfg_data);
        gdr_pkg::REG_PLANE_X:  cfg.plane_x       <= $signed(cfg_data);
        gdr_pkg::REG_PLANE_Y:  cfg.plane_y       <= $signed(cfg_data);
        gdr_pkg::REG_SCREEN_W: cfg.screen_width  <= cfg_data[10:0];
        gdr_pkg::REG_SCREEN_H: cfg.screen_height <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  gdr_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .column     (column),
    .clearing   (clearing),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_item  (push_item)
  );

  gdr_fifo #(.DEPTH(gdr_pkg::QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (push_item),
    .pop      (pop),
    .item_out (head_item),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  gdr_back #(.MAP_SIZE(MAP_SIZE), .TEX_WIDTH(TEX_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (fifo_empty),
    .fifo_item  (head_item),
    .fifo_pop   (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .column_out (column_out),
    .draw_start (draw_start),
    .draw_end   (draw_end),
    .tex_column (tex_column),
    .hit_side   (hit_side),
    .escaped    (escaped)
  );

endmodule
